### hw/rtl/aabb_affine_transform_unit_macros.svh
// Assertion helpers used by the checker of the box transform unit.
`ifndef AABB_AFFINE_TRANSFORM_UNIT_MACROS_SVH
`define AABB_AFFINE_TRANSFORM_UNIT_MACROS_SVH

// Clocked assertion, masked while reset is high.
`define AATU_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define AATU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/aabb_at_pkg.sv
`default_nettype none

package aabb_at_pkg;

   localparam int COORD_W   = 32;
   localparam int COEF_W    = 16;
   localparam int ROW_W     = 3 * COEF_W;
   localparam int FRAC_SH   = 14;
   localparam int PROD_W    = COORD_W + COEF_W;
   localparam int TERM_W    = PROD_W - FRAC_SH;
   localparam int ACC_W     = TERM_W + 2;
   localparam int NUM_AXES  = 3;
   localparam int CSR_AW    = 3;
   localparam int BOX_W     = 2 * NUM_AXES * COORD_W;

   // 1.0 in Q2.14
   localparam logic [COEF_W-1:0] COEF_ONE = 16'h4000;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [TERM_W-1:0]  term_type;
   typedef logic signed [ACC_W-1:0]   acc_type;
   typedef logic [ROW_W-1:0]          row_type;

   typedef enum logic [CSR_AW-1:0] {
      CSR_ROW_X   = 3'd0,
      CSR_ROW_Y   = 3'd1,
      CSR_ROW_Z   = 3'd2,
      CSR_SHIFT_X = 3'd3,
      CSR_SHIFT_Y = 3'd4,
      CSR_SHIFT_Z = 3'd5
   } csr_index_type;

   // load enables of the three pipeline stages
   typedef struct packed {
      logic mul;
      logic sel;
      logic sum;
   } stage_en_type;

   localparam acc_type SAT_MAX = acc_type'(33'sh0_7FFF_FFFF);
   localparam acc_type SAT_MIN = -acc_type'(33'sh0_8000_0000);

   function automatic coord_type sat32(input acc_type v);
      coord_type r;
      if (v > SAT_MAX) begin
         r = coord_type'(SAT_MAX);
      end else if (v < SAT_MIN) begin
         r = coord_type'(SAT_MIN);
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/aabb_affine_transform_unit.sv
`default_nettype none

// Axis-aligned box transform. Each req transaction carries one box (min and max
// corner, signed Q16.16); the block maps it through the programmed 3x3 Q2.14
// matrix plus Q16.16 translation and returns the bounding box of the eight
// mapped corners, every product floored and every coordinate clamped to 32 bits.
// Throughput is one box per clock while rsp is not stalled; there are three
// register stages per axis lane (multiply, term min/max, sum and clamp). Each
// stage holds its data while the next is stalled, so bubbles are squeezed out
// and req_tready falls only when all three stages hold boxes and rsp is stalled.
// The csr channel is always ready; registers should be rewritten only with no
// box in flight. After reset the map is the identity.
module aabb_affine_transform_unit (
   input  wire                               clock,
   input  wire                               reset,
   // req_tdata: lo_x, lo_y, lo_z, hi_x, hi_y, hi_z (32 bits each, lowest first)
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire  [aabb_at_pkg::BOX_W-1:0]     req_tdata,
   // rsp_tdata: out_lo_x, out_lo_y, out_lo_z, out_hi_x, out_hi_y, out_hi_z
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [aabb_at_pkg::BOX_W-1:0]     rsp_tdata,
   // register write: 0..2 coefficient rows, 3..5 translation; others ignored
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire  [aabb_at_pkg::CSR_AW-1:0]    csr_addr,
   input  wire  [aabb_at_pkg::ROW_W-1:0]     csr_wdata
);
   import aabb_at_pkg::*;

   row_type   row_ff   [NUM_AXES];
   coord_type shift_ff [NUM_AXES];

   coord_type box_lo [NUM_AXES];
   coord_type box_hi [NUM_AXES];
   coord_type res_lo [NUM_AXES];
   coord_type res_hi [NUM_AXES];

   logic v1_ff, v2_ff, v3_ff;
   logic v1_in, v2_in, v3_in;
   logic rdy1, rdy2, rdy3;
   stage_en_type en;

   // ---------------- configuration registers ----------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0]   <= row_type'(COEF_ONE);
         row_ff[1]   <= row_type'(COEF_ONE) << COEF_W;
         row_ff[2]   <= row_type'(COEF_ONE) << (2 * COEF_W);
         shift_ff[0] <= '0;
         shift_ff[1] <= '0;
         shift_ff[2] <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_addr))
            CSR_ROW_X:   row_ff[0]   <= csr_wdata;
            CSR_ROW_Y:   row_ff[1]   <= csr_wdata;
            CSR_ROW_Z:   row_ff[2]   <= csr_wdata;
            CSR_SHIFT_X: shift_ff[0] <= csr_wdata[COORD_W-1:0];
            CSR_SHIFT_Y: shift_ff[1] <= csr_wdata[COORD_W-1:0];
            CSR_SHIFT_Z: shift_ff[2] <= csr_wdata[COORD_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- pipeline control ----------------
   // a stage may load when it is empty or its contents move on this cycle
   assign rdy3 = !v3_ff || rsp_tready;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_tready = rdy1;

   assign en.mul = rdy1 && req_tvalid;
   assign en.sel = rdy2 && v1_ff;
   assign en.sum = rdy3 && v2_ff;

   assign v1_in = rdy1 ? req_tvalid : v1_ff;
   assign v2_in = rdy2 ? v1_ff : v2_ff;
   assign v3_in = rdy3 ? v2_ff : v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   assign rsp_tvalid = v3_ff;

   // ---------------- datapath: one lane per output axis ----------------
   for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
      assign box_lo[a] = req_tdata[a*COORD_W +: COORD_W];
      assign box_hi[a] = req_tdata[(a+NUM_AXES)*COORD_W +: COORD_W];

      aabb_at_lane u_lane (
         .clock  (clock),
         .en     (en),
         .row    (row_ff[a]),
         .shift  (shift_ff[a]),
         .box_lo (box_lo),
         .box_hi (box_hi),
         .out_lo (res_lo[a]),
         .out_hi (res_hi[a])
      );

      assign rsp_tdata[a*COORD_W +: COORD_W]            = res_lo[a];
      assign rsp_tdata[(a+NUM_AXES)*COORD_W +: COORD_W] = res_hi[a];
   end

endmodule

`default_nettype wire

### hw/rtl/aabb_at_lane.sv
`default_nettype none

// One output axis: six products, per-term min/max, then sum and clamp.
module aabb_at_lane (
   input  wire                       clock,
   input  aabb_at_pkg::stage_en_type en,
   input  aabb_at_pkg::row_type      row,
   input  aabb_at_pkg::coord_type    shift,
   input  aabb_at_pkg::coord_type    box_lo [aabb_at_pkg::NUM_AXES],
   input  aabb_at_pkg::coord_type    box_hi [aabb_at_pkg::NUM_AXES],
   output aabb_at_pkg::coord_type    out_lo,
   output aabb_at_pkg::coord_type    out_hi
);
   import aabb_at_pkg::*;

   logic signed [COEF_W-1:0] coef [NUM_AXES];
   logic signed [PROD_W-1:0] prod_lo [NUM_AXES];
   logic signed [PROD_W-1:0] prod_hi [NUM_AXES];

   term_type  term_lo_ff [NUM_AXES];
   term_type  term_hi_ff [NUM_AXES];
   term_type  min_ff     [NUM_AXES];
   term_type  max_ff     [NUM_AXES];
   acc_type   sum_lo, sum_hi;
   coord_type out_lo_ff, out_hi_ff;

   // stage 1: products, floored to Q16.16 by dropping the low 14 bits
   always_comb begin
      for (int k = 0; k < NUM_AXES; k++) begin
         coef[k]    = row[k*COEF_W +: COEF_W];
         prod_lo[k] = coef[k] * box_lo[k];
         prod_hi[k] = coef[k] * box_hi[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en.mul) begin
         for (int k = 0; k < NUM_AXES; k++) begin
            term_lo_ff[k] <= prod_lo[k][PROD_W-1:FRAC_SH];
            term_hi_ff[k] <= prod_hi[k][PROD_W-1:FRAC_SH];
         end
      end
   end

   // stage 2: terms are separable, so the corner extremes are sums of term extremes
   always_ff @(posedge clock) begin
      if (en.sel) begin
         for (int k = 0; k < NUM_AXES; k++) begin
            min_ff[k] <= (term_lo_ff[k] < term_hi_ff[k]) ? term_lo_ff[k] : term_hi_ff[k];
            max_ff[k] <= (term_lo_ff[k] < term_hi_ff[k]) ? term_hi_ff[k] : term_lo_ff[k];
         end
      end
   end

   // stage 3: sum and clamp; clamping is monotone so it commutes with min/max
   always_comb begin
      sum_lo = acc_type'(shift) + acc_type'(min_ff[0]) + acc_type'(min_ff[1])
             + acc_type'(min_ff[2]);
      sum_hi = acc_type'(shift) + acc_type'(max_ff[0]) + acc_type'(max_ff[1])
             + acc_type'(max_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (en.sum) begin
         out_lo_ff <= sat32(sum_lo);
         out_hi_ff <= sat32(sum_hi);
      end
   end

   assign out_lo = out_lo_ff;
   assign out_hi = out_hi_ff;

endmodule

`default_nettype wire

### hw/rtl/aabb_affine_transform_unit_checker.sv
`default_nettype none
`include "aabb_affine_transform_unit_macros.svh"

module aabb_affine_transform_unit_checker (
   input wire                            clock,
   input wire                            reset,
   input wire                            req_tvalid,
   input wire                            req_tready,
   input wire [aabb_at_pkg::BOX_W-1:0]   req_tdata,
   input wire                            rsp_tvalid,
   input wire                            rsp_tready,
   input wire [aabb_at_pkg::BOX_W-1:0]   rsp_tdata
);
   import aabb_at_pkg::*;

   // boxes accepted but not yet delivered
   logic [2:0] pend_ff, pend_in;
   logic       req_fire, rsp_fire;
   logic       req_data_seen;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;
   assign req_data_seen = ^req_tdata || 1'b1;

   always_comb begin
      pend_in = pend_ff;
      if (req_fire && !rsp_fire) begin
         pend_in = pend_ff + 3'd1;
      end else if (rsp_fire && !req_fire) begin
         pend_in = pend_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   `AATU_ASSERT_ALWAYS(a_idle_after_reset, clock, reset |=> !rsp_tvalid, "rsp valid after reset")
   `AATU_ASSERT(a_no_phantom, clock, reset, (pend_ff == 3'd0) |-> !rsp_tvalid, "rsp without request")
   `AATU_ASSERT(a_depth, clock, reset, req_data_seen |-> (pend_ff <= 3'd3), "more than three in flight")
   `AATU_ASSERT(a_full_stall, clock, reset, ((pend_ff == 3'd3) && !rsp_tready) |-> !req_tready, "accept while full and stalled")
   `AATU_ASSERT(a_rsp_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)), "stalled rsp changed")

endmodule

bind aabb_affine_transform_unit aabb_affine_transform_unit_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
